### hdl/ordered_list_engine_unit_macros.svh
// Assertion macros shared by the ordered list engine RTL.
`ifndef ORDERED_LIST_ENGINE_UNIT_MACROS_SVH
`define ORDERED_LIST_ENGINE_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// Consequent must hold in the same cycle as the antecedent.
`define OLE_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ordered list engine: same-cycle implication failed");
// Consequent must hold in the cycle after the antecedent.
`define OLE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ordered list engine: next-cycle implication failed");
// Condition must never be true.
`define OLE_ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("ordered list engine: forbidden condition seen");
`else
`define OLE_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define OLE_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`define OLE_ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

### hdl/ole_pkg.sv
// Shared types and constants of the ordered list engine.
`timescale 1ns / 1ps
package ole_pkg;

    localparam int DEPTH   = 16;
    localparam int VALUE_W = 32;
    localparam int IDX_W   = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int MODE_W  = 3;
    localparam int STAT_W  = 2;
    localparam int OUT_VAL_W = 32;
    localparam int OUT_CNT_W = 5;

    localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd0;
    localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_INSERT     = 3'd2;
    localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_POP_BACK   = 3'd4;
    localparam logic [MODE_W-1:0] MODE_REVERSE    = 3'd5;
    localparam logic [MODE_W-1:0] MODE_QUERY      = 3'd6;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;
    localparam logic [STAT_W-1:0] ST_SHORT = 2'd3;

    // The operation that every cell of the row performs on a command.
    typedef enum logic [2:0] {
        CELL_HOLD,      // keep the stored value
        CELL_INS_FWD,   // sorted insert, list held front to back
        CELL_INS_REV,   // sorted insert, list held back to front
        CELL_INS_HEAD,  // insert at cell 0
        CELL_INS_TAIL,  // insert at cell count
        CELL_DEL_HEAD   // remove cell 0, all cells move down
    } t_cell_op;

    typedef struct packed {
        t_cell_op             op;
        logic [VALUE_W-1:0]   value;
        logic [CNT_W-1:0]     count;
    } t_cell_ctrl;

endpackage

### hdl/ole_cell.sv
// One storage cell of the ordered list row, with its neighbor links.
`timescale 1ns / 1ps
module ole_cell (
    input  logic                       i_clk,
    input  logic [ole_pkg::IDX_W-1:0]  i_index,
    input  ole_pkg::t_cell_ctrl        i_ctrl,
    input  logic                       i_fwd_seen,
    output logic                       o_fwd_seen,
    input  logic                       i_rev_seen,
    output logic                       o_rev_seen,
    input  logic                       i_prev_after,
    output logic                       o_after,
    input  logic [ole_pkg::VALUE_W-1:0] i_prev_val,
    input  logic [ole_pkg::VALUE_W-1:0] i_next_val,
    output logic [ole_pkg::VALUE_W-1:0] o_val
);

    logic [ole_pkg::VALUE_W-1:0] r_val;
    logic [ole_pkg::VALUE_W-1:0] n_val;
    logic                        w_valid;
    logic                        w_ge;

    assign w_valid = ole_pkg::CNT_W'(i_index) < i_ctrl.count;
    assign w_ge    = r_val >= i_ctrl.value;

    // Front-to-back chain: set from the first cell that is not less than the
    // new value, or from the first empty cell.
    assign o_fwd_seen = i_fwd_seen | ~w_valid | w_ge;
    // Back-to-front chain: set from the last occupied cell not less than it.
    assign o_rev_seen = i_rev_seen | (w_valid & w_ge);

    always_comb begin
        case (i_ctrl.op)
            ole_pkg::CELL_INS_FWD:  o_after = o_fwd_seen;
            ole_pkg::CELL_INS_REV:  o_after = ~o_rev_seen;
            ole_pkg::CELL_INS_HEAD: o_after = 1'b1;
            ole_pkg::CELL_INS_TAIL: o_after = ~w_valid;
            default:                o_after = 1'b0;
        endcase
    end

    always_comb begin
        n_val = r_val;
        case (i_ctrl.op)
            ole_pkg::CELL_INS_FWD, ole_pkg::CELL_INS_REV,
            ole_pkg::CELL_INS_HEAD, ole_pkg::CELL_INS_TAIL: begin
                if (o_after) begin
                    n_val = i_prev_after ? i_prev_val : i_ctrl.value;
                end
            end
            ole_pkg::CELL_DEL_HEAD: n_val = i_next_val;
            default:                n_val = r_val;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

    assign o_val = r_val;

endmodule

### hdl/ordered_list_engine_unit.sv
// Top level of the ordered list engine: command decode, cell row and result register.
`timescale 1ns / 1ps
`include "ordered_list_engine_unit_macros.svh"
// The ordered list engine keeps up to 16 values of 32 bits in a row of
// identical cells and takes one command word at a time: push front, push
// back, sorted insert, pop front, pop back, reverse, or query (mode 7 acts
// as a query). Every command word produces exactly one result word with the
// status and the front value, back value and count after the command. A
// command enters the row in the cycle it is accepted; every cell compares
// its value with the new one and moves its value to a neighbor in that same
// cycle. The result word is formed from the updated row once the output
// register is free and held in that register, and a new command can be taken
// in the cycle its predecessor's result is loaded, giving up to one command
// per cycle while the downstream side keeps taking results. Reverse does
// not move any data: a direction flag changes how the row is read and how
// later commands map onto it.
module ordered_list_engine_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // Fields from bit 0 up: mode[2:0], value[34:3], zero fill[39:35].
    input  logic [39:0] i_s_tdata,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // Fields from bit 0 up: status[1:0], front_value[33:2], back_value[65:34],
    // count[70:66], is_empty[71].
    output logic [71:0] o_m_tdata
);

    localparam int IDX_W   = ole_pkg::IDX_W;
    localparam int CNT_W   = ole_pkg::CNT_W;
    localparam int VALUE_W = ole_pkg::VALUE_W;

    logic [ole_pkg::MODE_W-1:0] w_mode;
    logic [VALUE_W-1:0]         w_value;
    logic                       w_accept;

    assign w_mode   = i_s_tdata[2:0];
    assign w_value  = i_s_tdata[34:3];
    assign w_accept = i_s_tvalid & o_s_tready;

    // Control state of the list.
    logic [CNT_W-1:0]           r_count;
    logic [CNT_W-1:0]           n_count;
    logic                       r_rev;
    logic                       n_rev;
    // A command has updated the row and its result is still to be formed.
    logic                       r_pend;
    logic [ole_pkg::STAT_W-1:0] r_pend_status;
    logic [ole_pkg::STAT_W-1:0] n_status;
    logic                       r_ovalid;
    logic [71:0]                r_odata;

    ole_pkg::t_cell_ctrl        w_ctrl;
    ole_pkg::t_cell_op          w_op;

    logic                       w_full;
    logic                       w_empty;
    logic                       w_out_load;
    logic                       w_push_mode;

    assign w_full  = r_count == CNT_W'(ole_pkg::DEPTH);
    assign w_empty = r_count == '0;

    // Any of the three commands that add a value to the list.
    assign w_push_mode = (w_mode == ole_pkg::MODE_PUSH_FRONT) |
                         (w_mode == ole_pkg::MODE_PUSH_BACK) |
                         (w_mode == ole_pkg::MODE_INSERT);

    // Decode the command into one row operation. When the row is held back
    // to front, the two ends swap roles.
    always_comb begin
        w_op     = ole_pkg::CELL_HOLD;
        n_status = ole_pkg::ST_OK;
        n_count  = r_count;
        n_rev    = r_rev;
        case (w_mode)
            ole_pkg::MODE_PUSH_FRONT, ole_pkg::MODE_PUSH_BACK,
            ole_pkg::MODE_INSERT: begin
                if (w_full) begin
                    n_status = ole_pkg::ST_FULL;
                end else begin
                    n_count = r_count + CNT_W'(1);
                    if (w_mode == ole_pkg::MODE_INSERT) begin
                        w_op = r_rev ? ole_pkg::CELL_INS_REV : ole_pkg::CELL_INS_FWD;
                    end else if ((w_mode == ole_pkg::MODE_PUSH_FRONT) ^ r_rev) begin
                        w_op = ole_pkg::CELL_INS_HEAD;
                    end else begin
                        w_op = ole_pkg::CELL_INS_TAIL;
                    end
                end
            end
            ole_pkg::MODE_POP_FRONT, ole_pkg::MODE_POP_BACK: begin
                if (w_empty) begin
                    n_status = ole_pkg::ST_EMPTY;
                end else begin
                    n_count = r_count - CNT_W'(1);
                    // Removing the physical tail only needs the count to drop.
                    if ((w_mode == ole_pkg::MODE_POP_FRONT) ^ r_rev) begin
                        w_op = ole_pkg::CELL_DEL_HEAD;
                    end
                end
            end
            ole_pkg::MODE_REVERSE: begin
                if (r_count < CNT_W'(2)) begin
                    n_status = ole_pkg::ST_SHORT;
                end else begin
                    n_rev = ~r_rev;
                end
            end
            default: begin
                n_status = ole_pkg::ST_OK;
            end
        endcase
        if (!w_accept) begin
            w_op = ole_pkg::CELL_HOLD;
        end
    end

    assign w_ctrl.op    = w_op;
    assign w_ctrl.value = w_value;
    assign w_ctrl.count = r_count;

    // The cell row with its neighbor links.
    logic [ole_pkg::DEPTH:0]    w_fwd_seen;
    logic [ole_pkg::DEPTH:0]    w_rev_seen;
    logic [ole_pkg::DEPTH:0]    w_after;
    logic [VALUE_W-1:0]         w_cell_val [ole_pkg::DEPTH];

    assign w_fwd_seen[0]             = 1'b0;
    assign w_rev_seen[ole_pkg::DEPTH] = 1'b0;
    assign w_after[0]                = 1'b0;

    for (genvar g = 0; g < ole_pkg::DEPTH; g++) begin : g_cell
        logic [VALUE_W-1:0] w_prev_val;
        logic [VALUE_W-1:0] w_next_val;

        if (g == 0) begin : g_first
            assign w_prev_val = '0;
        end else begin : g_mid
            assign w_prev_val = w_cell_val[g-1];
        end
        if (g == ole_pkg::DEPTH - 1) begin : g_last
            assign w_next_val = w_cell_val[g];
        end else begin : g_body
            assign w_next_val = w_cell_val[g+1];
        end

        ole_cell u_cell (
            .i_clk        (i_clk),
            .i_index      (IDX_W'(g)),
            .i_ctrl       (w_ctrl),
            .i_fwd_seen   (w_fwd_seen[g]),
            .o_fwd_seen   (w_fwd_seen[g+1]),
            .i_rev_seen   (w_rev_seen[g+1]),
            .o_rev_seen   (w_rev_seen[g]),
            .i_prev_after (w_after[g]),
            .o_after      (w_after[g+1]),
            .i_prev_val   (w_prev_val),
            .i_next_val   (w_next_val),
            .o_val        (w_cell_val[g])
        );
    end

    // Result formation: the row already holds the state after the command.
    logic [CNT_W-1:0]   w_last;
    logic [VALUE_W-1:0] w_head_val;
    logic [VALUE_W-1:0] w_tail_val;
    logic [VALUE_W-1:0] w_front;
    logic [VALUE_W-1:0] w_back;

    assign w_last     = r_count - CNT_W'(1);
    assign w_head_val = w_cell_val[0];
    assign w_tail_val = w_cell_val[w_last[IDX_W-1:0]];
    assign w_front    = w_empty ? '0 : (r_rev ? w_tail_val : w_head_val);
    assign w_back     = w_empty ? '0 : (r_rev ? w_head_val : w_tail_val);

    assign w_out_load = r_pend & (~r_ovalid | i_m_tready);
    assign o_s_tready = ~r_pend | w_out_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_rev    <= 1'b0;
            r_pend   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count <= n_count;
                r_rev   <= n_rev;
            end
            if (w_accept) begin
                r_pend <= 1'b1;
            end else if (w_out_load) begin
                r_pend <= 1'b0;
            end
            if (w_out_load) begin
                r_ovalid <= 1'b1;
            end else if (i_m_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_pend_status <= n_status;
        end
        if (w_out_load) begin
            r_odata <= {w_empty, ole_pkg::OUT_CNT_W'(r_count), w_back, w_front,
                        r_pend_status};
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_odata;

    // The count never passes the capacity of the row.
    `OLE_ASSERT_NEVER(a_count_bound, i_clk, i_rst_n, r_count > CNT_W'(ole_pkg::DEPTH))
    // A pending command always reaches the output register once it is free.
    `OLE_ASSERT_NEXT(a_load_valid, i_clk, i_rst_n, w_out_load, o_m_tvalid)
    // A push or insert refused on a full list leaves the count unchanged.
    `OLE_ASSERT_NEXT(a_full_hold, i_clk, i_rst_n, w_accept && w_full && w_push_mode, $stable(r_count))
    // No new command is taken while an earlier result has not been formed.
    `OLE_ASSERT_IMPLY(a_one_pending, i_clk, i_rst_n, r_pend && !w_out_load, !o_s_tready)

endmodule

### test/ordered_list_engine_unit_test.sv
// Self-checking testbench for the ordered list engine with directed and random traffic.
`timescale 1ns / 1ps

module ordered_list_engine_unit_test;

    // Mode 7 has no name in the package; the block treats it as a query.
    localparam logic [ole_pkg::MODE_W-1:0] MODE_SPARE = 3'd7;

    // Cycles without any accepted word before the run is declared hung. The
    // slowest correct stretch is the deliberate receiver hold-off plus a few
    // sender gaps, far below this.
    localparam int STALL_LIMIT     = 2000;
    localparam int HOLD_OFF_CYCLES = 120;
    localparam int RANDOM_WORDS    = 300;

    typedef struct {
        logic [ole_pkg::STAT_W-1:0]    status;
        logic [ole_pkg::OUT_VAL_W-1:0] front_value;
        logic [ole_pkg::OUT_VAL_W-1:0] back_value;
        logic [ole_pkg::OUT_CNT_W-1:0] count;
        logic                          is_empty;
    } t_list_result;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    // Fields from bit 0 up: mode[2:0], value[34:3], zero fill[39:35].
    logic [39:0] i_s_tdata  = '0;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    // Fields from bit 0 up: status[1:0], front_value[33:2], back_value[65:34],
    // count[70:66], is_empty[71].
    logic [71:0] o_m_tdata;

    // Logical contents of the list, front at index 0, as the block should hold it.
    logic [ole_pkg::VALUE_W-1:0] list_contents[$];
    // Result words still owed by the block, oldest first.
    t_list_result                owed_results[$];

    int error_count     = 0;
    int words_sent      = 0;
    int results_checked = 0;
    int status_seen[4]  = '{0, 0, 0, 0};

    // Sender pacing state.
    bit gaps_on    = 1'b0;
    int burst_left = 0;

    // Receiver stall state; the tests request a hold-off by bumping hold_requests.
    int hold_requests = 0;
    int hold_served   = 0;
    int hold_left     = 0;
    int rx_style      = 0;
    int rx_style_left = 0;
    int rx_phase      = 0;

    int idle_cycles = 0;

    always #6 i_clk = ~i_clk;

    ordered_list_engine_unit DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    // Apply one accepted command to the list and queue the result word it owes.
    function automatic void apply_command(input logic [ole_pkg::MODE_W-1:0] mode,
                                          input logic [ole_pkg::VALUE_W-1:0] value);
        t_list_result                res;
        logic [ole_pkg::VALUE_W-1:0] flipped[$];
        int                          pos;
        int                          n;
        res.status = ole_pkg::ST_OK;
        case (mode)
            ole_pkg::MODE_PUSH_FRONT, ole_pkg::MODE_PUSH_BACK, ole_pkg::MODE_INSERT: begin
                if (list_contents.size() >= ole_pkg::DEPTH) begin
                    res.status = ole_pkg::ST_FULL;
                end else if (mode == ole_pkg::MODE_PUSH_FRONT) begin
                    list_contents.push_front(value);
                end else if (mode == ole_pkg::MODE_PUSH_BACK) begin
                    list_contents.push_back(value);
                end else begin
                    // The new value goes ahead of the first one that is not smaller.
                    pos = 0;
                    while (pos < list_contents.size() && list_contents[pos] < value)
                        pos++;
                    list_contents.insert(pos, value);
                end
            end
            ole_pkg::MODE_POP_FRONT: begin
                if (list_contents.size() == 0) res.status = ole_pkg::ST_EMPTY;
                else void'(list_contents.pop_front());
            end
            ole_pkg::MODE_POP_BACK: begin
                if (list_contents.size() == 0) res.status = ole_pkg::ST_EMPTY;
                else void'(list_contents.pop_back());
            end
            ole_pkg::MODE_REVERSE: begin
                if (list_contents.size() < 2) begin
                    res.status = ole_pkg::ST_SHORT;
                end else begin
                    foreach (list_contents[i]) flipped.push_front(list_contents[i]);
                    list_contents = flipped;
                end
            end
            default: begin
                // Query and the spare mode leave the list alone.
            end
        endcase
        n = list_contents.size();
        res.count       = n[ole_pkg::OUT_CNT_W-1:0];
        res.is_empty    = (n == 0);
        res.front_value = (n != 0) ? list_contents[0] : '0;
        res.back_value  = (n != 0) ? list_contents[n-1] : '0;
        owed_results.push_back(res);
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("[%0t] mismatch on %s: got %h, expected %h", $realtime, what, got, want);
        error_count++;
    endtask

    // Every accepted result word is compared with the oldest owed one.
    always @(posedge i_clk) begin
        t_list_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (owed_results.size() == 0) begin
                report_mismatch("result word with no command waiting",
                                o_m_tdata[31:0], '0);
            end else begin
                want = owed_results.pop_front();
                results_checked++;
                status_seen[o_m_tdata[1:0]]++;
                if (o_m_tdata[1:0] !== want.status)
                    report_mismatch("status", o_m_tdata[1:0], want.status);
                if (o_m_tdata[33:2] !== want.front_value)
                    report_mismatch("front_value", o_m_tdata[33:2], want.front_value);
                if (o_m_tdata[65:34] !== want.back_value)
                    report_mismatch("back_value", o_m_tdata[65:34], want.back_value);
                if (o_m_tdata[70:66] !== want.count)
                    report_mismatch("count", o_m_tdata[70:66], want.count);
                if (o_m_tdata[71] !== want.is_empty)
                    report_mismatch("is_empty", o_m_tdata[71], want.is_empty);
            end
        end
    end

    // Receiver: switches between randomly chosen stall styles, and goes
    // fully quiet for a counted stretch whenever a test asks for a hold-off.
    always @(posedge i_clk) begin
        if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            hold_left   = HOLD_OFF_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_m_tready <= 1'b0;
        end else begin
            if (rx_style_left == 0) begin
                rx_style      = $urandom_range(0, 3);
                rx_style_left = $urandom_range(20, 80);
            end
            rx_style_left--;
            rx_phase++;
            case (rx_style)
                0:       i_m_tready <= 1'b1;
                1:       i_m_tready <= ($urandom_range(0, 9) < 7);
                2:       i_m_tready <= ($urandom_range(0, 3) == 0);
                default: i_m_tready <= ((rx_phase % 5) < 3);
            endcase
        end
    end

    // Watchdog: ends the run if no word moves on either side for too long.
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("[%0t] no word moved for %0d cycles", $realtime, idle_cycles);
                $display("ordered_list_engine_unit_test NOT OK");
                $finish;
            end
        end
    end

    // Offer one command word and return at the edge where it is taken. The
    // caller stands just after a rising edge.
    task automatic send_word(input logic [ole_pkg::MODE_W-1:0] mode,
                             input logic [ole_pkg::VALUE_W-1:0] value);
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {5'b0, value, mode};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        apply_command(mode, value);
        words_sent++;
    endtask

    task automatic idle_for(input int cycles);
        i_s_tvalid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    // Bursts of random length separated by random gaps, while gaps are enabled.
    task automatic pace_sender();
        if (gaps_on) begin
            if (burst_left > 0) begin
                burst_left--;
            end else begin
                idle_for($urandom_range(1, 9));
                burst_left = $urandom_range(0, 15);
            end
        end
    endtask

    // Stop offering and wait until every owed result word has come back.
    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        do @(posedge i_clk); while (owed_results.size() != 0);
    endtask

    // Mode mix: grow leans on pushes, shrink on pops, anything else is balanced.
    function automatic logic [ole_pkg::MODE_W-1:0] pick_mode(input int bias);
        int                         weight[8];
        logic [ole_pkg::MODE_W-1:0] mode_order[8];
        int                         r;
        mode_order = '{ole_pkg::MODE_PUSH_FRONT, ole_pkg::MODE_PUSH_BACK,
                       ole_pkg::MODE_INSERT, ole_pkg::MODE_POP_FRONT,
                       ole_pkg::MODE_POP_BACK, ole_pkg::MODE_REVERSE,
                       ole_pkg::MODE_QUERY, MODE_SPARE};
        case (bias)
            0:       weight = '{20, 20, 35, 5, 5, 7, 4, 4};
            1:       weight = '{8, 8, 14, 25, 25, 8, 6, 6};
            default: weight = '{10, 10, 30, 15, 15, 10, 5, 5};
        endcase
        r = $urandom_range(0, 99);
        for (int m = 0; m < 8; m++) begin
            if (r < weight[m]) return mode_order[m];
            r -= weight[m];
        end
        return ole_pkg::MODE_QUERY;
    endfunction

    // Values lean toward extremes and repeats so that sorted inserts meet ties.
    function automatic logic [ole_pkg::VALUE_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return '0;
        if (r == 1) return '1;
        if (r <= 4) return $urandom_range(0, 7);
        if (r == 5 && list_contents.size() != 0)
            return list_contents[$urandom_range(0, list_contents.size() - 1)];
        return $urandom();
    endfunction

    // Query, both pops, reverse and the spare mode on an empty list.
    task automatic test_empty_list();
        send_word(ole_pkg::MODE_QUERY, $urandom());
        send_word(ole_pkg::MODE_POP_FRONT, $urandom());
        send_word(ole_pkg::MODE_POP_BACK, $urandom());
        send_word(ole_pkg::MODE_REVERSE, $urandom());
        send_word(MODE_SPARE, $urandom());
    endtask

    // Extreme values, ties in sorted insert, reverse on one element, and
    // sorted insert into a list that is held back to front.
    task automatic test_small_list();
        send_word(ole_pkg::MODE_PUSH_FRONT, 32'h0000_0000);
        send_word(ole_pkg::MODE_REVERSE, $urandom());
        send_word(ole_pkg::MODE_PUSH_BACK, 32'hFFFF_FFFF);
        send_word(ole_pkg::MODE_INSERT, 32'h8000_0000);
        send_word(ole_pkg::MODE_INSERT, 32'h8000_0000);
        send_word(ole_pkg::MODE_INSERT, 32'h0000_0000);
        send_word(ole_pkg::MODE_REVERSE, $urandom());
        send_word(ole_pkg::MODE_INSERT, 32'h0000_0001);
        send_word(ole_pkg::MODE_PUSH_FRONT, 32'h5555_5555);
        send_word(ole_pkg::MODE_PUSH_BACK, 32'hAAAA_AAAA);
        send_word(ole_pkg::MODE_POP_FRONT, $urandom());
        send_word(ole_pkg::MODE_POP_BACK, $urandom());
        send_word(ole_pkg::MODE_QUERY, 32'hFFFF_FFFF);
        send_word(MODE_SPARE, 32'hFFFF_FFFF);
        send_word(ole_pkg::MODE_REVERSE, $urandom());
        send_word(ole_pkg::MODE_POP_FRONT, $urandom());
        send_word(ole_pkg::MODE_POP_BACK, $urandom());
    endtask

    // Fill to capacity, try every kind of push on a full list, then empty it.
    task automatic test_fill_and_empty();
        logic [ole_pkg::MODE_W-1:0] fill_mode[3];
        fill_mode = '{ole_pkg::MODE_PUSH_FRONT, ole_pkg::MODE_PUSH_BACK,
                      ole_pkg::MODE_INSERT};
        while (list_contents.size() < ole_pkg::DEPTH)
            send_word(fill_mode[$urandom_range(0, 2)], pick_value());
        send_word(ole_pkg::MODE_PUSH_FRONT, $urandom());
        send_word(ole_pkg::MODE_PUSH_BACK, $urandom());
        send_word(ole_pkg::MODE_INSERT, 32'h0000_0000);
        send_word(ole_pkg::MODE_INSERT, 32'hFFFF_FFFF);
        send_word(ole_pkg::MODE_REVERSE, $urandom());
        send_word(ole_pkg::MODE_QUERY, $urandom());
        while (list_contents.size() != 0)
            send_word($urandom_range(0, 1) ? ole_pkg::MODE_POP_FRONT : ole_pkg::MODE_POP_BACK,
                      $urandom());
        send_word(ole_pkg::MODE_POP_BACK, $urandom());
    endtask

    // The receiver goes quiet while the sender keeps offering, so the block
    // backs up and must hold its input off without losing a word.
    task automatic test_hold_off();
        hold_requests++;
        repeat (40) send_word(pick_mode(2), pick_value());
        wait_drained();
    endtask

    // Random traffic in segments that grow, shrink or churn the list.
    task automatic test_random_traffic(input int words);
        int sent;
        int seg_left;
        int bias;
        sent     = 0;
        seg_left = 0;
        bias     = 0;
        while (sent < words) begin
            if (seg_left == 0) begin
                bias     = $urandom_range(0, 2);
                seg_left = $urandom_range(16, 48);
                gaps_on  = ($urandom_range(0, 3) != 0);
            end
            send_word(pick_mode(bias), pick_value());
            pace_sender();
            sent++;
            seg_left--;
        end
        gaps_on = 1'b0;
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_list();
        test_small_list();
        wait_drained();
        test_fill_and_empty();
        wait_drained();
        test_hold_off();
        test_random_traffic(RANDOM_WORDS);

        // Let the pipeline settle so that a stray extra word would be caught.
        wait_drained();
        repeat (4) @(posedge i_clk);

        $display("Sent %0d command words and checked %0d result words.",
                 words_sent, results_checked);
        $display("Statuses seen: ok %0d, full %0d, empty %0d, too short %0d.",
                 status_seen[ole_pkg::ST_OK], status_seen[ole_pkg::ST_FULL],
                 status_seen[ole_pkg::ST_EMPTY], status_seen[ole_pkg::ST_SHORT]);
        if (error_count == 0 && owed_results.size() == 0) begin
            $display("ordered_list_engine_unit_test OK");
        end else begin
            $display("ordered_list_engine_unit_test NOT OK");
        end
        $finish;
    end

endmodule
